FILE: rtl/core/htfp_pkg.sv
// ----------------------------------------------------------------------------
// htfp_pkg
// Shared types and constants for the header/tail frame parser: frame phases,
// register map, register reset values and the result item layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htfp_pkg;

  // Largest number of stored bytes in one frame, header bytes included.
  localparam int unsigned MAX_FRAME   = 10;
  // Stored-byte counter width; holds any frame length up to 15.
  localparam int unsigned FRAME_CNT_W = 4;
  // Number of stored bytes kept for field extraction.
  localparam int unsigned RECENT_DEPTH = 5;
  // Number of latched and published fields.
  localparam int unsigned FIELD_NUM   = 4;

  // Configuration register map (word index into the register list).
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_TAIL_BYTE     = 2'd2;

  // Register reset values.
  localparam logic [7:0] HEADER_FIRST_RST  = 8'h2C;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h12;
  localparam logic [7:0] TAIL_BYTE_RST     = 8'h5B;

  // Frame phases.
  typedef enum logic [1:0] {
    PH_HUNT1   = 2'd0,
    PH_HUNT2   = 2'd1,
    PH_COLLECT = 2'd2,
    PH_CLOSED  = 2'd3
  } phase_t;

  // One result item.
  typedef struct packed {
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] box_w;
    logic [7:0] box_h;
    logic       updated;
    logic       frame_error;
  } result_t;

endpackage : htfp_pkg

`default_nettype wire

FILE: rtl/core/htfp_core.sv
// ----------------------------------------------------------------------------
// htfp_core
// Per-byte frame rule: header hunt, data collection, field latching at frame
// close and publication on the byte after close. State advances on each
// accepted item; the result for that item is produced combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htfp_core
  import htfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_en,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] header_first,
  input  wire logic [7:0] header_second,
  input  wire logic [7:0] tail_byte,
  output result_t         result
);

  phase_t                 phase_r, phase_nxt;
  logic [FRAME_CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [FRAME_CNT_W-1:0] count_inc;
  logic [7:0]             recent_r    [RECENT_DEPTH];
  logic [7:0]             recent_nxt  [RECENT_DEPTH];
  logic [7:0]             pending_r   [FIELD_NUM];
  logic [7:0]             pending_nxt [FIELD_NUM];
  logic [7:0]             publish_r   [FIELD_NUM];
  logic [7:0]             publish_nxt [FIELD_NUM];
  logic                   complete_r, complete_nxt;
  logic                   upd, err;
  logic                   do_store, do_clear;

  assign count_inc = byte_count_r + FRAME_CNT_W'(1);

  // Phase decision: which of store, clear, close and publish this byte causes.
  always_comb begin
    phase_nxt    = phase_r;
    complete_nxt = complete_r;
    do_store     = 1'b0;
    do_clear     = 1'b0;
    upd          = 1'b0;
    err          = 1'b0;
    for (int i = 0; i < FIELD_NUM; i++) begin
      pending_nxt[i] = pending_r[i];
      publish_nxt[i] = publish_r[i];
    end
    unique case (phase_r)
      PH_HUNT1: begin
        if (rx_byte == header_first) begin
          do_store  = 1'b1;
          phase_nxt = PH_HUNT2;
        end else begin
          do_clear = 1'b1;
        end
      end
      PH_HUNT2: begin
        if (rx_byte == header_second) begin
          do_store  = 1'b1;
          phase_nxt = PH_COLLECT;
        end else begin
          do_clear = 1'b1;
          err      = 1'b1;
        end
      end
      PH_COLLECT: begin
        do_store = 1'b1;
        if (count_inc >= FRAME_CNT_W'(MAX_FRAME) || rx_byte == tail_byte) begin
          phase_nxt    = PH_CLOSED;
          complete_nxt = 1'b1;
          // Four stored bytes before the newest one, oldest first.
          for (int i = 0; i < FIELD_NUM; i++) begin
            pending_nxt[i] = recent_r[FIELD_NUM-1-i];
          end
        end
      end
      PH_CLOSED: begin
        do_clear = 1'b1;
        if (recent_r[0] == tail_byte) begin
          if (complete_r) begin
            upd = 1'b1;
            for (int i = 0; i < FIELD_NUM; i++) begin
              publish_nxt[i] = pending_r[i];
            end
          end
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        do_clear = 1'b1;
      end
    endcase
    // Going back to the hunt also drops the close flag.
    if (do_clear) begin
      phase_nxt    = PH_HUNT1;
      complete_nxt = 1'b0;
    end
  end

  // Stored-byte history and counter.
  always_comb begin
    byte_count_nxt = byte_count_r;
    for (int i = 0; i < RECENT_DEPTH; i++) begin
      recent_nxt[i] = recent_r[i];
    end
    if (do_clear) begin
      byte_count_nxt = '0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_nxt[i] = 8'h00;
      end
    end else if (do_store) begin
      byte_count_nxt = count_inc;
      for (int i = RECENT_DEPTH - 1; i > 0; i--) begin
        recent_nxt[i] = recent_r[i-1];
      end
      recent_nxt[0] = rx_byte;
    end
  end

  // State registers advance on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT1;
      byte_count_r <= '0;
      complete_r   <= 1'b0;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_r[i] <= 8'h00;
      end
      for (int i = 0; i < FIELD_NUM; i++) begin
        pending_r[i] <= 8'h00;
        publish_r[i] <= 8'h00;
      end
    end else if (item_en) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      complete_r   <= complete_nxt;
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        recent_r[i] <= recent_nxt[i];
      end
      for (int i = 0; i < FIELD_NUM; i++) begin
        pending_r[i] <= pending_nxt[i];
        publish_r[i] <= publish_nxt[i];
      end
    end
  end

  // Result for the byte being accepted.
  always_comb begin
    result.pos_x       = publish_nxt[0];
    result.pos_y       = publish_nxt[1];
    result.box_w       = publish_nxt[2];
    result.box_h       = publish_nxt[3];
    result.updated     = upd;
    result.frame_error = err;
  end

endmodule : htfp_core

`default_nettype wire

FILE: rtl/core/htfp_out_buf.sv
// ----------------------------------------------------------------------------
// htfp_out_buf
// Two-entry output stage: a result register plus a skid register, so the
// input side can take one more item while a finished result waits downstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htfp_out_buf
  import htfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  result_t   push_data,
  output logic      push_ready,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output result_t   pop_data
);

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_data_r, main_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    pop;

  assign pop        = main_valid_r && pop_ready;
  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_data_r;

  // Fill order: the result register first, the skid register when it is held.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      main_valid_nxt = 1'b0;
    end
    if (pop && skid_valid_r) begin
      main_valid_nxt = 1'b1;
      main_data_nxt  = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_nxt = 1'b1;
        main_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule : htfp_out_buf

`default_nettype wire

FILE: rtl/core/header_tail_frame_parser_unit.sv
// Each result item enters the output stage when its input item is accepted.
// Throughput: one item per cycle while in_ready is high; the per-byte
// rule is a single pass of logic between the state and result registers.
// A two-entry output stage keeps in_ready high while one result waits.
// Reset (rst_n low, synchronous) returns to header hunt with zeroed history
// and published fields, and restores the register reset values.
// ----------------------------------------------------------------------------
// header_tail_frame_parser_unit
// Byte-serial frame parser with a two-byte header and a tail byte; publishes
// x, y, width and height from each well-formed frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module header_tail_frame_parser_unit
  import htfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input item channel.
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_rx_byte,
  // Result item channel.
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_pos_x,
  output logic [7:0]                 out_pos_y,
  output logic [7:0]                 out_box_w,
  output logic [7:0]                 out_box_h,
  output logic                       out_updated,
  output logic                       out_frame_error,
  // Configuration port.
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [7:0] header_first_r;
  logic [7:0] header_second_r;
  logic [7:0] tail_byte_r;
  logic [1:0] reg_index;
  logic       cfg_write;
  logic       in_accept;
  result_t    core_result;
  result_t    out_data;

  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_accept = in_valid && in_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= HEADER_FIRST_RST;
      header_second_r <= HEADER_SECOND_RST;
      tail_byte_r     <= TAIL_BYTE_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_HEADER_FIRST:  header_first_r  <= pwdata[7:0];
        REG_HEADER_SECOND: header_second_r <= pwdata[7:0];
        REG_TAIL_BYTE:     tail_byte_r     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_HEADER_FIRST:  prdata = {24'd0, header_first_r};
      REG_HEADER_SECOND: prdata = {24'd0, header_second_r};
      REG_TAIL_BYTE:     prdata = {24'd0, tail_byte_r};
      default:           prdata = '0;
    endcase
  end

  // Frame rule.
  htfp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_en       (in_accept),
    .rx_byte       (in_rx_byte),
    .header_first  (header_first_r),
    .header_second (header_second_r),
    .tail_byte     (tail_byte_r),
    .result        (core_result)
  );

  // Result register with skid stage.
  htfp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_data  (core_result),
    .push_ready (in_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_data)
  );

  assign out_pos_x       = out_data.pos_x;
  assign out_pos_y       = out_data.pos_y;
  assign out_box_w       = out_data.box_w;
  assign out_box_h       = out_data.box_h;
  assign out_updated     = out_data.updated;
  assign out_frame_error = out_data.frame_error;

endmodule : header_tail_frame_parser_unit

`default_nettype wire

FILE: rtl/core/htfp_checker.sv
// ----------------------------------------------------------------------------
// htfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htfp_checker
  import htfp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_pos_x,
  input wire logic [7:0] out_pos_y,
  input wire logic [7:0] out_box_w,
  input wire logic [7:0] out_box_h,
  input wire logic       out_updated,
  input wire logic       out_frame_error
);

  // A byte can never both publish and flag a malformed frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_updated && out_frame_error))
    else $error("result item both published and flagged an error");

  // A held result keeps its payload until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_box_w) && $stable(out_box_h) && $stable(out_updated)
      && $stable(out_frame_error))
    else $error("stalled result item changed");

  // With no result pending, the input side must be open.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  // Reset empties the output stage.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item offered right after reset");

endmodule : htfp_checker

bind header_tail_frame_parser_unit htfp_checker u_htfp_checker (.*);

`default_nettype wire
